// ===== design/fte_pkg.sv =====
// Shared types, constants and helpers of the timestamp-to-epoch converter.
// No dependencies; every other design file but fte_stream_if refers to it by scoped names.
package fte_pkg;

	// Fraction gathering modes
	localparam logic [1:0] FRAC_NONE   = 2'd0;
	localparam logic [1:0] FRAC_GATHER = 2'd1;
	localparam logic [1:0] FRAC_STOP   = 2'd2;

	localparam int unsigned MULT_W = 47;	// wide enough for ns per day

	localparam logic [MULT_W-1:0] NS_PER_DAY  = 47'd86_400_000_000_000;
	localparam logic [MULT_W-1:0] NS_PER_HOUR = 47'd3_600_000_000_000;
	localparam logic [MULT_W-1:0] NS_PER_MIN  = 47'd60_000_000_000;
	localparam logic [MULT_W-1:0] NS_PER_SEC  = 47'd1_000_000_000;

	// Day-count constants
	localparam logic [23:0] DAYS_PER_ERA   = 24'd146097;
	localparam logic [23:0] EPOCH_SHIFT    = 24'd719468;

	// Input and output transfer payloads
	typedef struct packed {
		logic [7:0] char_byte;
		logic       last;
	} text_t;

	typedef struct packed {
		logic [63:0] timestamp_ns;
		logic        format_error;
	} result_t;

	// Gathered fields of one timestamp string
	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [29:0] frac;
		logic [3:0]  frac_digits;
		logic [1:0]  frac_mode;
		logic        bad;
		logic        short_text;
	} fields_t;

	// Command to the shift-add multiply-accumulate unit
	typedef struct packed {
		logic              load;
		logic              clear_acc;
		logic [63:0]       mcand;
		logic [MULT_W-1:0] mplier;
	} mac_cmd_t;

	// 10^n for n in 0..9
	function automatic logic [29:0] pow10(input logic [3:0] n);
		logic [29:0] r;
		case (n)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			4'd9: r = 30'd1000000000;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/fte_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from fte_pkg at instantiation.
interface fte_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/fix_timestamp_to_epoch_ns.sv =====
// Timestamp text to nanoseconds since the epoch, top level.
// Depends on fte_pkg, fte_stream_if, fte_parse and fte_mac.
//
// Usage:
// text   (sink): one ASCII byte per transfer, payload.last marks the final
//                byte of a "YYYYMMDD-HH:MM:SS[.fffffffff]" string.
// result (source): one transfer per string: timestamp_ns (mod 2^64) and
//                format_error (non-digit in a date/time digit or fewer
//                than 17 bytes).
// Bytes are taken one per cycle while the block gathers a string. After the
// last byte, text.ready stays low while the day-count steps C0 to C3 and
// five multiply-accumulate passes run; the passes go through one shared
// shift-add unit at one multiplier bit per cycle, so how long they take
// depends on the number of fraction digits.
// The result sits in an output register; a new string is taken as soon as
// the result is in that register, even while the receiver stalls it. A new
// result waits only if the previous one has not been taken yet.
// Reset clears the gathered fields and leaves no result pending.
module fix_timestamp_to_epoch_ns (
	input logic         clk,
	input logic         arst_n,
	fte_stream_if.sink   text,
	fte_stream_if.source result
);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_C0   = 3'd1;
	localparam logic [2:0] S_C1   = 3'd2;
	localparam logic [2:0] S_C2   = 3'd3;
	localparam logic [2:0] S_C3   = 3'd4;
	localparam logic [2:0] S_LOAD = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	// Multiply-accumulate passes
	localparam logic [2:0] OP_DAYS = 3'd0;
	localparam logic [2:0] OP_HOUR = 3'd1;
	localparam logic [2:0] OP_MIN  = 3'd2;
	localparam logic [2:0] OP_SEC  = 3'd3;
	localparam logic [2:0] OP_FRAC = 3'd4;

	logic [2:0] state_q;
	logic [2:0] op_q;

	fte_pkg::fields_t  fields;
	fte_pkg::mac_cmd_t mac_cmd;
	logic [63:0]       mac_acc;
	logic              mac_idle;

	logic take, clear, load_out;

	// Day-count registers
	logic [13:0] y_q;
	logic        y_neg_q;
	logic [6:0]  era_q;
	logic [14:0] mpx_q;
	logic [8:0]  yoe_q;
	logic [12:0] doy_q;
	logic [18:0] doe_q;
	logic [23:0] eraday_q;
	logic [23:0] days_q;

	logic        out_valid_q;
	logic [63:0] out_ns_q;
	logic        out_err_q;

	// Byte gathering
	assign text.ready = (state_q == S_IDLE);
	assign take       = text.valid && text.ready;

	fte_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_byte (text.payload.char_byte),
		.clear     (clear),
		.fields    (fields)
	);

	fte_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.acc    (mac_acc),
		.idle   (mac_idle)
	);

	// Stage C0: shifted year, era, month index
	logic        m_le2;
	logic [14:0] y_c;
	logic [20:0] era_prod;
	logic [6:0]  mp_c;

	assign m_le2    = (fields.month <= 7'd2);
	assign y_c      = {1'b0, fields.year} - {14'd0, m_le2};
	assign era_prod = 21'(y_c[13:4]) * 21'd1311;	// floor(y/16/25)
	assign mp_c     = m_le2 ? fields.month + 7'd9 : fields.month - 7'd3;

	// Stage C1: year of era, day of year
	logic [30:0] d5_prod;
	logic [13:0] era_x400;

	assign d5_prod  = 31'(mpx_q) * 31'd52429;	// floor(x/5)
	assign era_x400 = 14'(era_q[5:0]) * 14'd400;

	// Stage C2: day of era, era days
	logic [17:0] yoe365;
	logic [14:0] yoe41;

	assign yoe365 = 18'(yoe_q) * 18'd365;
	assign yoe41  = 15'(yoe_q) * 15'd41;	// floor(yoe/100) in [14:12]

	always_ff @(posedge clk) begin
		case (state_q)
			S_C0: begin
				y_q     <= y_c[13:0];
				y_neg_q <= y_c[14];
				era_q   <= y_c[14] ? 7'h7F : {1'b0, era_prod[20:15]};
				mpx_q   <= 15'(mp_c) * 15'd153 + 15'd2;
			end
			S_C1: begin
				yoe_q <= y_neg_q ? 9'd399 : 9'(y_q - era_x400);
				doy_q <= d5_prod[30:18] + 13'(fields.day) - 13'd1;
			end
			S_C2: begin
				doe_q <= 19'(yoe365) + 19'(yoe_q[8:2]) - 19'(yoe41[14:12])
					+ {{6{doy_q[12]}}, doy_q};
				eraday_q <= 24'($signed(era_q)) * $signed(fte_pkg::DAYS_PER_ERA);
			end
			S_C3: begin
				days_q <= eraday_q + {{5{doe_q[18]}}, doe_q} - fte_pkg::EPOCH_SHIFT;
			end
			default: begin
			end
		endcase
	end

	// Operands of each multiply-accumulate pass
	always_comb begin
		mac_cmd.load      = (state_q == S_LOAD);
		mac_cmd.clear_acc = (op_q == OP_DAYS);
		case (op_q)
			OP_DAYS: begin
				mac_cmd.mcand  = {{40{days_q[23]}}, days_q};
				mac_cmd.mplier = fte_pkg::NS_PER_DAY;
			end
			OP_HOUR: begin
				mac_cmd.mcand  = 64'(fields.hour);
				mac_cmd.mplier = fte_pkg::NS_PER_HOUR;
			end
			OP_MIN: begin
				mac_cmd.mcand  = 64'(fields.minute);
				mac_cmd.mplier = fte_pkg::NS_PER_MIN;
			end
			OP_SEC: begin
				mac_cmd.mcand  = 64'(fields.second);
				mac_cmd.mplier = fte_pkg::NS_PER_SEC;
			end
			OP_FRAC: begin
				mac_cmd.mcand  = 64'(fields.frac);
				mac_cmd.mplier = (fields.frac_mode != fte_pkg::FRAC_NONE)
					? fte_pkg::MULT_W'(fte_pkg::pow10(4'd9 - fields.frac_digits))
					: '0;
			end
			default: begin
				mac_cmd.mcand  = '0;
				mac_cmd.mplier = '0;
			end
		endcase
	end

	// Result hand-off to the output register
	assign load_out = (state_q == S_OUT) && (!out_valid_q || result.ready);
	assign clear    = load_out;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_DAYS;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take && text.payload.last) begin
						state_q <= S_C0;
					end
				end
				S_C0: state_q <= S_C1;
				S_C1: state_q <= S_C2;
				S_C2: state_q <= S_C3;
				S_C3: begin
					op_q    <= OP_DAYS;
					state_q <= S_LOAD;
				end
				S_LOAD: state_q <= S_WAIT;
				S_WAIT: begin
					if (mac_idle) begin
						if (op_q == OP_FRAC) begin
							state_q <= S_OUT;
						end else begin
							op_q    <= op_q + 3'd1;
							state_q <= S_LOAD;
						end
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ns_q  <= mac_acc;
			out_err_q <= fields.bad || fields.short_text;
		end
	end

	assign result.valid                = out_valid_q;
	assign result.payload.timestamp_ns = out_ns_q;
	assign result.payload.format_error = out_err_q;

endmodule

// ===== design/fte_parse.sv =====
// Byte-wise field gatherer: decimal date/time fields and the fraction.
// Depends on fte_pkg (fields_t, fraction mode codes).
module fte_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       char_byte,
	input  logic             clear,
	output fte_pkg::fields_t fields
);

	logic [4:0]  pos_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;
	logic [29:0] frac_q;
	logic [3:0]  digits_q;
	logic [1:0]  mode_q;
	logic        bad_q, short_q;

	logic       is_digit;
	logic [3:0] dval;
	logic       in_field;

	// Digit decode; a non-digit counts as zero
	assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
	assign dval     = is_digit ? 4'(char_byte - 8'h30) : 4'd0;
	// Fixed digit positions: 0..16 less the separators at 8, 11, 14
	assign in_field = (pos_q <= 5'd16) && (pos_q != 5'd8) && (pos_q != 5'd11)
		&& (pos_q != 5'd14);

	// Field accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q   <= '0;
			digits_q <= '0;
			mode_q   <= fte_pkg::FRAC_NONE;
			bad_q    <= 1'b0;
			short_q  <= 1'b0;
		end else if (clear) begin
			pos_q    <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q   <= '0;
			digits_q <= '0;
			mode_q   <= fte_pkg::FRAC_NONE;
			bad_q    <= 1'b0;
			short_q  <= 1'b0;
		end else if (take) begin
			if (pos_q <= 5'd3) begin
				year_q <= year_q * 14'd10 + 14'(dval);
			end else if (pos_q <= 5'd5) begin
				month_q <= month_q * 7'd10 + 7'(dval);
			end else if (pos_q <= 5'd7) begin
				day_q <= day_q * 7'd10 + 7'(dval);
			end else if (pos_q == 5'd9 || pos_q == 5'd10) begin
				hour_q <= hour_q * 7'd10 + 7'(dval);
			end else if (pos_q == 5'd12 || pos_q == 5'd13) begin
				minute_q <= minute_q * 7'd10 + 7'(dval);
			end else if (pos_q == 5'd15 || pos_q == 5'd16) begin
				second_q <= second_q * 7'd10 + 7'(dval);
			end else if (pos_q == 5'd17) begin
				if (char_byte == 8'h2E) begin
					mode_q <= fte_pkg::FRAC_GATHER;
				end
			end else if (mode_q == fte_pkg::FRAC_GATHER) begin
				// stop for good on a non-digit or after nine digits
				if (is_digit && digits_q < 4'd9) begin
					frac_q   <= frac_q * 30'd10 + 30'(dval);
					digits_q <= digits_q + 4'd1;
				end else begin
					mode_q <= fte_pkg::FRAC_STOP;
				end
			end

			if (in_field && !is_digit) begin
				bad_q <= 1'b1;
			end
			// text shorter than 17 bytes if this is the last one
			short_q <= (pos_q < 5'd16);
			if (pos_q != 5'd31) begin
				pos_q <= pos_q + 5'd1;
			end
		end
	end

	assign fields = '{
		year:        year_q,
		month:       month_q,
		day:         day_q,
		hour:        hour_q,
		minute:      minute_q,
		second:      second_q,
		frac:        frac_q,
		frac_digits: digits_q,
		frac_mode:   mode_q,
		bad:         bad_q,
		short_text:  short_q
	};

endmodule

// ===== design/fte_mac.sv =====
// Shift-add multiply-accumulate unit, one multiplier bit per cycle.
// Depends on fte_pkg (mac_cmd_t, MULT_W).
module fte_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  fte_pkg::mac_cmd_t cmd,
	output logic [63:0]       acc,
	output logic              idle
);

	logic [63:0]                mcand_q;
	logic [63:0]                acc_q;
	logic [fte_pkg::MULT_W-1:0] mplier_q;

	// Multiplier bits drive the iteration; zero means done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mplier_q <= '0;
		end else if (cmd.load) begin
			mplier_q <= cmd.mplier;
		end else if (mplier_q != '0) begin
			mplier_q <= mplier_q >> 1;
		end
	end

	// Datapath: shifted multiplicand added into the accumulator, mod 2^64
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mcand_q <= cmd.mcand;
			if (cmd.clear_acc) begin
				acc_q <= '0;
			end
		end else if (mplier_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
		end
	end

	assign acc  = acc_q;
	assign idle = (mplier_q == '0);

endmodule
